// ----- hdl/encoder_setpoint_adjust_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the encoder setpoint adjuster.
// Concurrent checks with and without a reset qualifier.
// ----------------------------------------------------------------------------
`ifndef ENCODER_SETPOINT_ADJUST_ASSERT_SVH
`define ENCODER_SETPOINT_ADJUST_ASSERT_SVH

// Check that is switched off while reset is high.
`define ESA_ASSERT(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("encoder setpoint adjust check failed");

// Check that also holds across reset.
`define ESA_ASSERT_ALWAYS(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) \
    else $error("encoder setpoint adjust reset check failed");

`endif

// ----- hdl/esa_pkg.sv -----
// ----------------------------------------------------------------------------
// esa_pkg
// Types, codes and the quadrature transition table of the setpoint adjuster.
// ----------------------------------------------------------------------------
package esa_pkg;

  // Decoder state codes.
  localparam logic [2:0] ST_START     = 3'd0;
  localparam logic [2:0] ST_CW_FINAL  = 3'd1;
  localparam logic [2:0] ST_CW_BEGIN  = 3'd2;
  localparam logic [2:0] ST_CW_NEXT   = 3'd3;
  localparam logic [2:0] ST_CCW_BEGIN = 3'd4;
  localparam logic [2:0] ST_CCW_FINAL = 3'd5;
  localparam logic [2:0] ST_CCW_NEXT  = 3'd6;

  // Direction codes.
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_CW   = 2'd1;
  localparam logic [1:0] DIR_CCW  = 2'd2;

  // Operating modes.
  localparam logic [1:0] MODE_LINKED  = 2'd0;
  localparam logic [1:0] MODE_VOLTAGE = 2'd1;

  // Configuration register indexes.
  localparam logic [2:0] REG_PWM_LIMIT     = 3'd0;
  localparam logic [2:0] REG_CURRENT_LIMIT = 3'd1;
  localparam logic [2:0] REG_VOLTAGE_LIMIT = 3'd2;
  localparam logic [2:0] REG_PWM_STEP      = 3'd3;
  localparam logic [2:0] REG_CURRENT_STEP  = 3'd4;
  localparam logic [2:0] REG_VOLTAGE_STEP  = 3'd5;

  localparam int CFG_DATA_W = 10;

  // Reset values of the configuration registers.
  localparam logic [9:0] PWM_LIMIT_RST     = 10'd800;
  localparam logic [7:0] CURRENT_LIMIT_RST = 8'd200;
  localparam logic [8:0] VOLTAGE_LIMIT_RST = 9'd420;
  localparam logic [5:0] PWM_STEP_RST      = 6'd8;
  localparam logic [3:0] CURRENT_STEP_RST  = 4'd2;
  localparam logic [3:0] VOLTAGE_STEP_RST  = 4'd2;

  typedef struct packed {
    logic [9:0] pwm_limit;
    logic [7:0] current_limit;
    logic [8:0] voltage_limit;
    logic [5:0] pwm_step;
    logic [3:0] current_step;
    logic [3:0] voltage_step;
  } cfg_t;

  typedef struct packed {
    logic [2:0] decoder_state;
    logic [9:0] pwm_value;
    logic [7:0] current_value;
    logic [8:0] voltage_value;
  } state_t;

  typedef struct packed {
    logic [1:0] dir;
    logic [2:0] state;
  } quad_t;

  // Full-step transition table. The pin pair is {pin_b, pin_a}; a detent is
  // reported on the step that closes a full cycle back to the start state.
  function automatic quad_t quad_next(input logic [2:0] st, input logic [1:0] pins);
    quad_t q;
    q.dir = DIR_NONE;
    q.state = ST_START;
    case (st)
      ST_CW_FINAL: begin
        case (pins)
          2'd0: q.state = ST_CW_NEXT;
          2'd2: q.state = ST_CW_FINAL;
          2'd3: q.dir   = DIR_CW;
          default: q.state = ST_START;
        endcase
      end
      ST_CW_BEGIN: begin
        case (pins)
          2'd0: q.state = ST_CW_NEXT;
          2'd1: q.state = ST_CW_BEGIN;
          default: q.state = ST_START;
        endcase
      end
      ST_CW_NEXT: begin
        case (pins)
          2'd0: q.state = ST_CW_NEXT;
          2'd1: q.state = ST_CW_BEGIN;
          2'd2: q.state = ST_CW_FINAL;
          default: q.state = ST_START;
        endcase
      end
      ST_CCW_BEGIN: begin
        case (pins)
          2'd0: q.state = ST_CCW_NEXT;
          2'd2: q.state = ST_CCW_BEGIN;
          default: q.state = ST_START;
        endcase
      end
      ST_CCW_FINAL: begin
        case (pins)
          2'd0: q.state = ST_CCW_NEXT;
          2'd1: q.state = ST_CCW_FINAL;
          2'd3: q.dir   = DIR_CCW;
          default: q.state = ST_START;
        endcase
      end
      ST_CCW_NEXT: begin
        case (pins)
          2'd0: q.state = ST_CCW_NEXT;
          2'd1: q.state = ST_CCW_FINAL;
          2'd2: q.state = ST_CCW_BEGIN;
          default: q.state = ST_START;
        endcase
      end
      default: begin
        // Start state, and the unused code that behaves like it.
        case (pins)
          2'd1: q.state = ST_CW_BEGIN;
          2'd2: q.state = ST_CCW_BEGIN;
          default: q.state = ST_START;
        endcase
      end
    endcase
    return q;
  endfunction

endpackage

// ----- hdl/esa_if.sv -----
// ----------------------------------------------------------------------------
// esa_sample_if / esa_result_if
// Valid/ready channels for encoder samples and setpoint results.
// ----------------------------------------------------------------------------
interface esa_sample_if;
  logic       valid;
  logic       ready;
  logic       pin_a;
  logic       pin_b;
  logic [1:0] mode;

  modport source (output valid, output pin_a, output pin_b, output mode, input ready);
  modport sink   (input valid, input pin_a, input pin_b, input mode, output ready);
endinterface

interface esa_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] direction;
  logic [9:0] pwm_setpoint;
  logic [7:0] current_setpoint;
  logic [8:0] voltage_setpoint;

  modport source (output valid, output direction, output pwm_setpoint,
                  output current_setpoint, output voltage_setpoint, input ready);
  modport sink   (input valid, input direction, input pwm_setpoint,
                  input current_setpoint, input voltage_setpoint, output ready);
endinterface

// ----- hdl/encoder_setpoint_adjust.sv -----
// ----------------------------------------------------------------------------
// encoder_setpoint_adjust
// Rotary encoder decoder that steps PWM, current and voltage setpoints.
// ----------------------------------------------------------------------------
// One encoder sample is taken every clock while the result side keeps up,
// and each sample gives one result: the sample lands in an input register,
// and the decoder step plus the clamped add or subtract sit between that
// register and the result register, which also holds the setpoints. The
// result register stalls when the result side is not ready, and the input
// register keeps taking samples until it is full as well. Configuration
// writes take effect on the next clock edge.
module encoder_setpoint_adjust (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [2:0]                      cfg_index,
  input  logic [esa_pkg::CFG_DATA_W-1:0]  cfg_data,
  esa_sample_if.sink                      sample,
  esa_result_if.source                    result
);

  esa_pkg::cfg_t   cfg;
  esa_pkg::state_t st;
  esa_pkg::state_t st_next;
  logic [1:0]      dir_next;
  logic [1:0]      res_dir;
  logic            res_valid;
  logic            in_valid;
  logic            in_pin_a;
  logic            in_pin_b;
  logic [1:0]      in_mode;
  logic            advance;

  // Pipeline flow control.
  assign advance      = !res_valid || result.ready;
  assign sample.ready = !in_valid || advance;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pwm_limit     <= esa_pkg::PWM_LIMIT_RST;
      cfg.current_limit <= esa_pkg::CURRENT_LIMIT_RST;
      cfg.voltage_limit <= esa_pkg::VOLTAGE_LIMIT_RST;
      cfg.pwm_step      <= esa_pkg::PWM_STEP_RST;
      cfg.current_step  <= esa_pkg::CURRENT_STEP_RST;
      cfg.voltage_step  <= esa_pkg::VOLTAGE_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        esa_pkg::REG_PWM_LIMIT:     cfg.pwm_limit     <= cfg_data[9:0];
        esa_pkg::REG_CURRENT_LIMIT: cfg.current_limit <= cfg_data[7:0];
        esa_pkg::REG_VOLTAGE_LIMIT: cfg.voltage_limit <= cfg_data[8:0];
        esa_pkg::REG_PWM_STEP:      cfg.pwm_step      <= cfg_data[5:0];
        esa_pkg::REG_CURRENT_STEP:  cfg.current_step  <= cfg_data[3:0];
        esa_pkg::REG_VOLTAGE_STEP:  cfg.voltage_step  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample.ready) begin
      in_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      in_pin_a <= sample.pin_a;
      in_pin_b <= sample.pin_b;
      in_mode  <= sample.mode;
    end
  end

  esa_update u_update (
    .cfg   (cfg),
    .cur   (st),
    .pin_a (in_pin_a),
    .pin_b (in_pin_b),
    .mode  (in_mode),
    .nxt   (st_next),
    .dir   (dir_next)
  );

  // State and result register; the setpoints double as the result payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.decoder_state <= esa_pkg::ST_START;
      st.pwm_value     <= 10'd0;
      st.current_value <= 8'd0;
      st.voltage_value <= 9'd0;
      res_valid        <= 1'b0;
      res_dir          <= esa_pkg::DIR_NONE;
    end else if (advance) begin
      res_valid <= in_valid;
      if (in_valid) begin
        st      <= st_next;
        res_dir <= dir_next;
      end
    end
  end

  assign result.valid            = res_valid;
  assign result.direction        = res_dir;
  assign result.pwm_setpoint     = st.pwm_value;
  assign result.current_setpoint = st.current_value;
  assign result.voltage_setpoint = st.voltage_value;

endmodule

// ----- hdl/esa_update.sv -----
// ----------------------------------------------------------------------------
// esa_update
// Decoder step and clamped setpoint update for one encoder sample.
// ----------------------------------------------------------------------------
module esa_update (
  input  esa_pkg::cfg_t   cfg,
  input  esa_pkg::state_t cur,
  input  logic            pin_a,
  input  logic            pin_b,
  input  logic [1:0]      mode,
  output esa_pkg::state_t nxt,
  output logic [1:0]      dir
);

  esa_pkg::quad_t q;
  logic [10:0]    pwm_up;
  logic [8:0]     cur_up;
  logic [9:0]     volt_up;
  logic [9:0]     pwm_inc;
  logic [7:0]     cur_inc;
  logic [8:0]     volt_inc;
  logic [9:0]     pwm_dec;
  logic [7:0]     cur_dec;
  logic [8:0]     volt_dec;

  // Decoder table lookup.
  assign q   = esa_pkg::quad_next(cur.decoder_state, {pin_b, pin_a});
  assign dir = q.dir;

  // Increase clamped to the limit.
  assign pwm_up   = {1'b0, cur.pwm_value} + {5'd0, cfg.pwm_step};
  assign cur_up   = {1'b0, cur.current_value} + {5'd0, cfg.current_step};
  assign volt_up  = {1'b0, cur.voltage_value} + {6'd0, cfg.voltage_step};
  assign pwm_inc  = (pwm_up > {1'b0, cfg.pwm_limit}) ? cfg.pwm_limit : pwm_up[9:0];
  assign cur_inc  = (cur_up > {1'b0, cfg.current_limit}) ? cfg.current_limit : cur_up[7:0];
  assign volt_inc = (volt_up > {1'b0, cfg.voltage_limit}) ? cfg.voltage_limit : volt_up[8:0];

  // Decrease clamped to zero.
  assign pwm_dec  = (cur.pwm_value >= {4'd0, cfg.pwm_step}) ?
                    cur.pwm_value - {4'd0, cfg.pwm_step} : 10'd0;
  assign cur_dec  = (cur.current_value >= {4'd0, cfg.current_step}) ?
                    cur.current_value - {4'd0, cfg.current_step} : 8'd0;
  assign volt_dec = (cur.voltage_value >= {5'd0, cfg.voltage_step}) ?
                    cur.voltage_value - {5'd0, cfg.voltage_step} : 9'd0;

  // Apply the detent to the setpoints selected by the mode.
  always_comb begin
    nxt = cur;
    nxt.decoder_state = q.state;
    if (q.dir == esa_pkg::DIR_CW) begin
      if (mode == esa_pkg::MODE_LINKED) begin
        if (cur.pwm_value < cfg.pwm_limit && cur.current_value < cfg.current_limit) begin
          nxt.pwm_value     = pwm_inc;
          nxt.current_value = cur_inc;
        end
      end else if (mode == esa_pkg::MODE_VOLTAGE) begin
        if (cur.voltage_value < cfg.voltage_limit) begin
          nxt.voltage_value = volt_inc;
        end
      end
    end else if (q.dir == esa_pkg::DIR_CCW) begin
      if (mode == esa_pkg::MODE_LINKED) begin
        if (cur.pwm_value != 10'd0 && cur.current_value != 8'd0) begin
          nxt.pwm_value     = pwm_dec;
          nxt.current_value = cur_dec;
        end
      end else if (mode == esa_pkg::MODE_VOLTAGE) begin
        if (cur.voltage_value != 9'd0) begin
          nxt.voltage_value = volt_dec;
        end
      end
    end
  end

endmodule

// ----- hdl/esa_checker.sv -----
// ----------------------------------------------------------------------------
// esa_checker
// Port-level checks of the encoder setpoint adjuster, bound to the top level.
// ----------------------------------------------------------------------------
`include "encoder_setpoint_adjust_assert.svh"

module esa_checker (
  input logic       clk,
  input logic       rst,
  input logic       sample_valid,
  input logic       sample_ready,
  input logic       result_valid,
  input logic       result_ready,
  input logic [1:0] result_direction
);

  // No result is presented right after reset.
  `ESA_ASSERT_ALWAYS(a_idle_after_reset, clk, $past(rst) |-> !result_valid)

  // A stalled result stays presented.
  `ESA_ASSERT(a_result_holds, clk, rst, result_valid && !result_ready |=> result_valid)

  // Only the three direction codes appear.
  `ESA_ASSERT(a_dir_code, clk, rst, result_valid |-> result_direction <= esa_pkg::DIR_CCW)

  // An accepted sample is presented as a result if the result side is ready while it sits in the input register.
  `ESA_ASSERT(a_latency, clk, rst,
    sample_valid && sample_ready ##1 result_ready |=> result_valid)

endmodule

bind encoder_setpoint_adjust esa_checker u_esa_checker (
  .clk              (clk),
  .rst              (rst),
  .sample_valid     (sample.valid),
  .sample_ready     (sample.ready),
  .result_valid     (result.valid),
  .result_ready     (result.ready),
  .result_direction (result.direction)
);

// ----- verif/encoder_setpoint_adjust_test.sv -----
// ----------------------------------------------------------------------------
// encoder_setpoint_adjust_test
// Self-checking testbench for the encoder setpoint adjuster.
// ----------------------------------------------------------------------------
// A short table of directed samples and register writes comes first, then
// six phases of random encoder traffic, each under its own register setting.
// Most random traffic is clean detent cycles with random mode and direction,
// the rest is aborted cycles and pin noise. Every accepted sample goes through
// a local model of the quadrature decoder and the clamped setpoint moves, and
// every accepted result is compared field by field with the oldest expectation.
// Both sides of the block idle at random, and once the result side holds off
// long enough to back the block up into its sample input.
module encoder_setpoint_adjust_test;

  // Mode codes beyond the two that the package names.
  localparam logic [1:0] MODE_DISCHARGE = 2'd2;
  localparam logic [1:0] MODE_SPARE     = 2'd3;

  // Register indexes past the last register; writes to them do nothing.
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  localparam int PHASE_ITEMS = 305;
  localparam int HOLD_CYCLES = 60;

  typedef struct packed {
    logic [1:0] dir;
    logic [9:0] pwm;
    logic [7:0] current;
    logic [8:0] voltage;
  } setpoints_t;

  // A typed expectation travels with the sample it belongs to.
  typedef struct packed {
    bit         typed;
    setpoints_t want;
  } sample_note_t;

  typedef struct packed {
    bit         is_write;
    logic [2:0] index;
    logic [9:0] data;
    logic [1:0] pins;
    logic [1:0] mode;
    bit         typed;
    setpoints_t want;
  } plan_row_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [2:0]                     cfg_index;
  logic [esa_pkg::CFG_DATA_W-1:0] cfg_data;

  esa_sample_if sample_ch ();
  esa_result_if result_ch ();

  encoder_setpoint_adjust uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_ch),
    .result    (result_ch)
  );

  // Local copy of the decoder, the setpoints and the registers.
  logic [2:0]    quad_state;
  logic [9:0]    pwm_now;
  logic [7:0]    current_now;
  logic [8:0]    voltage_now;
  esa_pkg::cfg_t knobs;

  setpoints_t   setpoint_queue [$];
  sample_note_t typed_notes [$];
  sample_note_t note_now;
  setpoints_t   got_now;
  setpoints_t   want_now;

  int mismatch_count;
  int result_count;
  int src_idle_pct;
  int sink_idle_pct;
  int hold_asks;
  int holds_taken;
  int hold_left;

  // Clock with a period of two time units.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #200000;
    $display("encoder_setpoint_adjust: mismatch");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("ERROR: %s", what);
  endtask

  function automatic int raise_clamped(input int value, input int step, input int limit);
    return (value + step > limit) ? limit : value + step;
  endfunction

  function automatic int lower_clamped(input int value, input int step);
    return (value >= step) ? value - step : 0;
  endfunction

  // Advance the decoder by one pin sample and apply any detent to the
  // setpoints that the mode selects.
  function automatic setpoints_t step_setpoints(input logic [1:0] pins,
                                                input logic [1:0] m);
    logic [11:0] row;
    logic [1:0]  dir;
    // Each row lists the next state for pin pairs 3, 2, 1, 0.
    case (quad_state)
      esa_pkg::ST_CW_FINAL:
        row = {esa_pkg::ST_START, esa_pkg::ST_CW_FINAL,
               esa_pkg::ST_START, esa_pkg::ST_CW_NEXT};
      esa_pkg::ST_CW_BEGIN:
        row = {esa_pkg::ST_START, esa_pkg::ST_START,
               esa_pkg::ST_CW_BEGIN, esa_pkg::ST_CW_NEXT};
      esa_pkg::ST_CW_NEXT:
        row = {esa_pkg::ST_START, esa_pkg::ST_CW_FINAL,
               esa_pkg::ST_CW_BEGIN, esa_pkg::ST_CW_NEXT};
      esa_pkg::ST_CCW_BEGIN:
        row = {esa_pkg::ST_START, esa_pkg::ST_CCW_BEGIN,
               esa_pkg::ST_START, esa_pkg::ST_CCW_NEXT};
      esa_pkg::ST_CCW_FINAL:
        row = {esa_pkg::ST_START, esa_pkg::ST_START,
               esa_pkg::ST_CCW_FINAL, esa_pkg::ST_CCW_NEXT};
      esa_pkg::ST_CCW_NEXT:
        row = {esa_pkg::ST_START, esa_pkg::ST_CCW_BEGIN,
               esa_pkg::ST_CCW_FINAL, esa_pkg::ST_CCW_NEXT};
      default:
        row = {esa_pkg::ST_START, esa_pkg::ST_CCW_BEGIN,
               esa_pkg::ST_CW_BEGIN, esa_pkg::ST_START};
    endcase
    dir = esa_pkg::DIR_NONE;
    if (pins == 2'b11 && quad_state == esa_pkg::ST_CW_FINAL) begin
      dir = esa_pkg::DIR_CW;
    end else if (pins == 2'b11 && quad_state == esa_pkg::ST_CCW_FINAL) begin
      dir = esa_pkg::DIR_CCW;
    end
    quad_state = row[pins * 3 +: 3];

    // Linked needs both setpoints free to move; modes past voltage hold still.
    if (dir == esa_pkg::DIR_CW && m == esa_pkg::MODE_LINKED) begin
      if (pwm_now < knobs.pwm_limit && current_now < knobs.current_limit) begin
        pwm_now     = 10'(raise_clamped(pwm_now, knobs.pwm_step, knobs.pwm_limit));
        current_now = 8'(raise_clamped(current_now, knobs.current_step,
                                       knobs.current_limit));
      end
    end else if (dir == esa_pkg::DIR_CW && m == esa_pkg::MODE_VOLTAGE) begin
      if (voltage_now < knobs.voltage_limit) begin
        voltage_now = 9'(raise_clamped(voltage_now, knobs.voltage_step,
                                       knobs.voltage_limit));
      end
    end else if (dir == esa_pkg::DIR_CCW && m == esa_pkg::MODE_LINKED) begin
      if (pwm_now > 0 && current_now > 0) begin
        pwm_now     = 10'(lower_clamped(pwm_now, knobs.pwm_step));
        current_now = 8'(lower_clamped(current_now, knobs.current_step));
      end
    end else if (dir == esa_pkg::DIR_CCW && m == esa_pkg::MODE_VOLTAGE) begin
      if (voltage_now > 0) begin
        voltage_now = 9'(lower_clamped(voltage_now, knobs.voltage_step));
      end
    end
    return '{dir, pwm_now, current_now, voltage_now};
  endfunction

  // Track register writes, predict each accepted item and check each result.
  always @(posedge clk) begin
    if (rst) begin
      quad_state  = esa_pkg::ST_START;
      pwm_now     = '0;
      current_now = '0;
      voltage_now = '0;
      knobs = '{esa_pkg::PWM_LIMIT_RST, esa_pkg::CURRENT_LIMIT_RST,
                esa_pkg::VOLTAGE_LIMIT_RST, esa_pkg::PWM_STEP_RST,
                esa_pkg::CURRENT_STEP_RST, esa_pkg::VOLTAGE_STEP_RST};
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          esa_pkg::REG_PWM_LIMIT:     knobs.pwm_limit     = cfg_data[9:0];
          esa_pkg::REG_CURRENT_LIMIT: knobs.current_limit = cfg_data[7:0];
          esa_pkg::REG_VOLTAGE_LIMIT: knobs.voltage_limit = cfg_data[8:0];
          esa_pkg::REG_PWM_STEP:      knobs.pwm_step      = cfg_data[5:0];
          esa_pkg::REG_CURRENT_STEP:  knobs.current_step  = cfg_data[3:0];
          esa_pkg::REG_VOLTAGE_STEP:  knobs.voltage_step  = cfg_data[3:0];
          default: ;
        endcase
      end

      if (sample_ch.valid && sample_ch.ready) begin
        note_now = (typed_notes.size() != 0) ? typed_notes.pop_front() : '0;
        want_now = step_setpoints({sample_ch.pin_b, sample_ch.pin_a}, sample_ch.mode);
        setpoint_queue.push_back(note_now.typed ? note_now.want : want_now);
      end

      if (result_ch.valid && result_ch.ready) begin
        got_now = '{result_ch.direction, result_ch.pwm_setpoint,
                    result_ch.current_setpoint, result_ch.voltage_setpoint};
        if (setpoint_queue.size() == 0) begin
          flag_mismatch($sformatf("result %0d arrived with nothing expected",
                                  result_count));
        end else begin
          want_now = setpoint_queue.pop_front();
          if (got_now.dir !== want_now.dir)
            flag_mismatch($sformatf("result %0d direction %0d, want %0d",
                                    result_count, got_now.dir, want_now.dir));
          if (got_now.pwm !== want_now.pwm)
            flag_mismatch($sformatf("result %0d pwm_setpoint %0d, want %0d",
                                    result_count, got_now.pwm, want_now.pwm));
          if (got_now.current !== want_now.current)
            flag_mismatch($sformatf("result %0d current_setpoint %0d, want %0d",
                                    result_count, got_now.current, want_now.current));
          if (got_now.voltage !== want_now.voltage)
            flag_mismatch($sformatf("result %0d voltage_setpoint %0d, want %0d",
                                    result_count, got_now.voltage, want_now.voltage));
        end
        result_count++;
      end
    end
  end

  // Result side: random ready, with a long hold-off whenever one is asked for.
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != holds_taken) begin
        holds_taken = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Offer one sample, with random idle cycles ahead of it, and wait until
  // it is taken. Starts and ends at a falling edge.
  task automatic send_sample(input logic [1:0] pins, input logic [1:0] m,
                             input bit typed, input setpoints_t want);
    typed_notes.push_back('{typed, want});
    while ($urandom_range(99) < src_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.pin_a <= pins[0];
    sample_ch.pin_b <= pins[1];
    sample_ch.mode  <= m;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic wait_drained();
    int guard;
    guard = 0;
    sample_ch.valid <= 1'b0;
    @(negedge clk);
    while (setpoint_queue.size() != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] index, input logic [9:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  function automatic plan_row_t reg_row(input logic [2:0] index, input logic [9:0] data);
    return '{1'b1, index, data, 2'd0, esa_pkg::MODE_LINKED, 1'b0, '0};
  endfunction

  function automatic plan_row_t pin_row(input logic [1:0] pins, input logic [1:0] m,
                                        input bit typed, input setpoints_t want);
    return '{1'b0, 3'd0, 10'd0, pins, m, typed, want};
  endfunction

  // Mostly adjusting modes, with some discharge and spare-code samples.
  function automatic logic [1:0] any_mode();
    int r;
    r = $urandom_range(99);
    if (r < 45) return esa_pkg::MODE_LINKED;
    if (r < 80) return esa_pkg::MODE_VOLTAGE;
    if (r < 92) return MODE_DISCHARGE;
    return MODE_SPARE;
  endfunction

  // Stimulus.
  initial begin
    plan_row_t  plan [$];
    logic [9:0] regval [6];
    logic [7:0] walk;
    logic [1:0] m;
    int         phase;
    int         sent;
    int         pick;
    int         steps;
    int         lean;
    bit         cw;
    bit         hold_done;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sample_ch.valid = 1'b0;
    sample_ch.pin_a = 1'b0;
    sample_ch.pin_b = 1'b0;
    sample_ch.mode = esa_pkg::MODE_LINKED;
    src_idle_pct = 17;
    sink_idle_pct = 55;
    hold_asks = 0;
    holds_taken = 0;
    hold_left = 0;
    mismatch_count = 0;
    result_count = 0;
    hold_done = 1'b0;
    lean = 50;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. Clockwise pins run 1, 0, 2, 3 and counter-clockwise
    // pins run 2, 0, 1, 3; the detent lands on the final 3.
    plan = '{
      // Both pins high straight out of reset: no detent, all setpoints zero.
      pin_row(2'd3, esa_pkg::MODE_LINKED, 1'b1, '{esa_pkg::DIR_NONE, 10'd0, 8'd0, 9'd0}),
      // Counter-clockwise at zero: the linked pair must not move.
      pin_row(2'd2, esa_pkg::MODE_LINKED, 1'b0, '0),
      pin_row(2'd0, esa_pkg::MODE_LINKED, 1'b0, '0),
      pin_row(2'd1, esa_pkg::MODE_LINKED, 1'b0, '0),
      pin_row(2'd3, esa_pkg::MODE_LINKED, 1'b1, '{esa_pkg::DIR_CCW, 10'd0, 8'd0, 9'd0}),
      // A PWM step that overshoots its limit; the high data bits are dropped.
      reg_row(esa_pkg::REG_PWM_LIMIT, 10'd10),
      reg_row(esa_pkg::REG_CURRENT_LIMIT, 10'h3FF),
      reg_row(esa_pkg::REG_PWM_STEP, 10'h3FF),
      reg_row(esa_pkg::REG_CURRENT_STEP, 10'h3FF),
      pin_row(2'd1, esa_pkg::MODE_LINKED, 1'b0, '0),
      pin_row(2'd0, esa_pkg::MODE_LINKED, 1'b0, '0),
      pin_row(2'd2, esa_pkg::MODE_LINKED, 1'b0, '0),
      pin_row(2'd3, esa_pkg::MODE_LINKED, 1'b1, '{esa_pkg::DIR_CW, 10'd10, 8'd15, 9'd0}),
      // Limit dropped under the value; counter-clockwise still lowers it.
      reg_row(esa_pkg::REG_PWM_LIMIT, 10'd0),
      pin_row(2'd2, esa_pkg::MODE_LINKED, 1'b0, '0),
      pin_row(2'd0, esa_pkg::MODE_LINKED, 1'b0, '0),
      pin_row(2'd1, esa_pkg::MODE_LINKED, 1'b0, '0),
      pin_row(2'd3, esa_pkg::MODE_LINKED, 1'b1, '{esa_pkg::DIR_CCW, 10'd0, 8'd0, 9'd0}),
      // Zero voltage step, and writes past the last register that change nothing.
      reg_row(esa_pkg::REG_VOLTAGE_LIMIT, 10'h1FF),
      reg_row(esa_pkg::REG_VOLTAGE_STEP, 10'd0),
      reg_row(REG_SPARE_LO, 10'd0),
      reg_row(REG_SPARE_HI, 10'd0),
      pin_row(2'd1, esa_pkg::MODE_VOLTAGE, 1'b0, '0),
      pin_row(2'd0, esa_pkg::MODE_VOLTAGE, 1'b0, '0),
      pin_row(2'd2, esa_pkg::MODE_VOLTAGE, 1'b0, '0),
      pin_row(2'd3, esa_pkg::MODE_VOLTAGE, 1'b1, '{esa_pkg::DIR_CW, 10'd0, 8'd0, 9'd0}),
      // Discharge mode and the spare mode code report the detent only.
      reg_row(esa_pkg::REG_VOLTAGE_STEP, 10'd15),
      pin_row(2'd1, MODE_DISCHARGE, 1'b0, '0),
      pin_row(2'd0, MODE_DISCHARGE, 1'b0, '0),
      pin_row(2'd2, MODE_DISCHARGE, 1'b0, '0),
      pin_row(2'd3, MODE_DISCHARGE, 1'b1, '{esa_pkg::DIR_CW, 10'd0, 8'd0, 9'd0}),
      pin_row(2'd1, MODE_SPARE, 1'b0, '0),
      pin_row(2'd0, MODE_SPARE, 1'b0, '0),
      pin_row(2'd2, MODE_SPARE, 1'b0, '0),
      pin_row(2'd3, MODE_SPARE, 1'b1, '{esa_pkg::DIR_CW, 10'd0, 8'd0, 9'd0}),
      pin_row(2'd1, esa_pkg::MODE_VOLTAGE, 1'b0, '0),
      pin_row(2'd0, esa_pkg::MODE_VOLTAGE, 1'b0, '0),
      pin_row(2'd2, esa_pkg::MODE_VOLTAGE, 1'b0, '0),
      pin_row(2'd3, esa_pkg::MODE_VOLTAGE, 1'b1, '{esa_pkg::DIR_CW, 10'd0, 8'd0, 9'd15})
    };

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        wait_drained();
        cfg_write(plan[i].index, plan[i].data);
      end else begin
        send_sample(plan[i].pins, plan[i].mode, plan[i].typed, plan[i].want);
      end
    end

    // Random phases, each under its own register setting and idle pattern.
    for (phase = 0; phase < 6; phase++) begin
      wait_drained();
      src_idle_pct  <= (phase < 2) ? 17 : (phase < 4) ? 55 : 0;
      sink_idle_pct <= (phase < 2) ? 55 : (phase < 4) ? 17 : 0;

      // Widest limits with the finest steps, then zero limits with the
      // coarsest steps, then random data with the high bits live.
      case (phase)
        0: regval = '{10'd1023, 10'd255, 10'd511, 10'd1, 10'd1, 10'd1};
        1: regval = '{10'd0, 10'd0, 10'd0, 10'd63, 10'd15, 10'd15};
        default: begin
          foreach (regval[r]) regval[r] = 10'($urandom_range(1023));
        end
      endcase
      for (int r = esa_pkg::REG_PWM_LIMIT; r <= esa_pkg::REG_VOLTAGE_STEP; r++) begin
        cfg_write(3'(r), regval[r]);
      end
      cfg_write($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO,
                10'($urandom_range(1023)));

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // Once, let the result side stall while samples keep coming.
        if (phase == 4 && sent >= 20 && !hold_done) begin
          hold_done = 1'b1;
          hold_asks <= hold_asks + 1;
        end
        // Lean toward one direction for a while so setpoints reach the rails.
        if ($urandom_range(9) == 0) lean = $urandom_range(2) * 35 + 15;

        pick = $urandom_range(99);
        if (pick < 85) begin
          // Detent cycle, whole or cut short, with occasional repeated pins.
          cw = ($urandom_range(99) < lean);
          m = any_mode();
          walk = cw ? {2'd3, 2'd2, 2'd0, 2'd1} : {2'd3, 2'd1, 2'd0, 2'd2};
          steps = (pick < 70) ? 4 : $urandom_range(1, 3);
          for (int k = 0; k < steps; k++) begin
            send_sample(walk[2 * k +: 2], m, 1'b0, '0);
            sent++;
            if (k < 3 && $urandom_range(3) == 0) begin
              send_sample(walk[2 * k +: 2], m, 1'b0, '0);
              sent++;
            end
          end
          if (steps < 4) begin
            send_sample(2'($urandom_range(3)), any_mode(), 1'b0, '0);
            sent++;
          end
        end else begin
          // Pin noise.
          send_sample(2'($urandom_range(3)), any_mode(), 1'b0, '0);
          sent++;
        end
      end
    end

    wait_drained();
    if (setpoint_queue.size() != 0) begin
      flag_mismatch($sformatf("%0d expected results never arrived",
                              setpoint_queue.size()));
    end
    if (mismatch_count == 0) begin
      $display("encoder_setpoint_adjust: match");
    end else begin
      $display("encoder_setpoint_adjust: mismatch");
    end
    $finish;
  end

endmodule
